// ===== src/glmf_pkg.sv =====
`default_nettype none

package glmf_pkg;

  // Grid limits and value width.
  localparam int MAX_COLS   = 128;
  localparam int MAX_ROWS   = 128;
  localparam int VALUE_BITS = 16;

  // Field widths.
  localparam int COL_BITS   = 8;
  localparam int ROW_BITS   = 8;
  localparam int COUNT_BITS = 15;
  localparam int RING_BITS  = $clog2(MAX_COLS);
  localparam int DRAIN_BITS = $clog2(2 * MAX_COLS);

  // Reset value of the columns register.
  localparam logic [COL_BITS-1:0] COLS_RESET = COL_BITS'(MAX_COLS);

  typedef logic signed [VALUE_BITS-1:0] value_t;

  // The two buffered rows of one grid column.
  typedef struct packed {
    value_t upper;
    value_t middle;
  } column_t;

  // Control of the line buffer chain.
  typedef struct packed {
    logic clear;
    logic shift;
  } line_ctrl_t;

  // Control of the minimum tracker.
  typedef struct packed {
    logic clear;
    logic push;
    logic check;
  } eval_ctrl_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== src/grid_local_minimum_finder.sv =====
// Channel   Direction  Transaction
// s_*       in         one grid cell: tdata = pixel_value, tlast = last_pixel
// m_*       out        one result per grid: tdata = count/value/row/col, tuser = found
// cfg_*     in         write of the columns register, taken at once
//
// A cell is taken once the line ring has turned to its column; the ring has MAX_COLS
// cells and turns once round for each row, idling past the MAX_COLS - ncols empty cells.
// After the last cell the block pushes zeros to the row end and one zero row,
// up to 2 * ncols - 1 pushes at the same ring pace, then posts the result from ST_DONE.
// Reset clears the ring, counters and result; columns returns to 128.
// A waiting result does not stall input; only a second finished grid waits for it.
`default_nettype none

module grid_local_minimum_finder
  import glmf_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [COL_BITS-1:0] cfg_wr_data,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [15:0]         s_tdata,   // [15:0] pixel_value
  input  logic                s_tlast,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [47:0]         m_tdata,   // [14:0] minima_count, [30:15] min_value,
                                         // [38:31] min_row, [46:39] min_col, [47] zero
  output logic                m_tuser    // [0] found
);

  state_t                state;
  state_t                state_next;
  logic [COL_BITS-1:0]   columns;
  logic [COL_BITS-1:0]   ncols;
  logic [COL_BITS-1:0]   col_pos;
  logic [ROW_BITS-1:0]   row_pos;
  logic [RING_BITS-1:0]  ring_pos;
  logic [DRAIN_BITS-1:0] drain_left;

  logic                  wrap_now;
  logic [COL_BITS-1:0]   eff_col;
  logic [ROW_BITS-1:0]   eff_row;
  logic [COL_BITS-1:0]   col_after;
  logic                  last_in_row;
  logic                  aligned;
  logic                  run_push;
  logic                  drain_push;
  logic                  push;
  logic                  frame_clear;
  value_t                below;

  line_ctrl_t            line_ctrl;
  eval_ctrl_t            eval_ctrl;
  column_t               head;
  column_t               wrap_in;
  value_t                second_middle;
  value_t                tail_upper;
  value_t                left;
  value_t                right;

  logic [COUNT_BITS-1:0] count;
  logic                  any_found;
  value_t                best_value;
  logic [ROW_BITS-1:0]   best_row;
  logic [COL_BITS-1:0]   best_col;

  function automatic logic [ROW_BITS-1:0] row_inc(input logic [ROW_BITS-1:0] r);
    return (r < ROW_BITS'(MAX_ROWS)) ? r + ROW_BITS'(1) : r;
  endfunction

  // Columns register.
  always_ff @(posedge clk) begin
    if (rst) begin
      columns <= COLS_RESET;
    end else if (cfg_wr_en) begin
      columns <= cfg_wr_data;
    end
  end

  // Effective row width: zero acts as one, large values clip to the ring size.
  always_comb begin
    if (columns == '0) begin
      ncols = COL_BITS'(1);
    end else if (columns > COL_BITS'(MAX_COLS)) begin
      ncols = COL_BITS'(MAX_COLS);
    end else begin
      ncols = columns;
    end
  end

  // Position of the cell about to be pushed, after a pending row wrap.
  always_comb begin
    wrap_now    = (col_pos >= ncols);
    eff_col     = wrap_now ? '0 : col_pos;
    eff_row     = wrap_now ? row_inc(row_pos) : row_pos;
    col_after   = eff_col + COL_BITS'(1);
    last_in_row = (col_after >= ncols);
    aligned     = (ring_pos == eff_col[RING_BITS-1:0]);
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_RUN: begin
        if (run_push && s_tlast) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_push && (drain_left == DRAIN_BITS'(1))) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (frame_clear) begin
          state_next = ST_RUN;
        end
      end
      default: state_next = ST_RUN;
    endcase
  end

  // State machine outputs.
  always_comb begin
    s_tready    = 1'b0;
    run_push    = 1'b0;
    drain_push  = 1'b0;
    frame_clear = 1'b0;
    unique case (state)
      ST_RUN: begin
        s_tready = aligned;
        run_push = aligned && s_tvalid;
      end
      ST_DRAIN: begin
        drain_push = aligned;
      end
      ST_DONE: begin
        frame_clear = !m_tvalid || m_tready;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  // Neighborhood of the head column.
  always_comb begin
    push      = run_push || drain_push;
    below     = drain_push ? value_t'(0) : value_t'(s_tdata);
    left      = (eff_col == '0) ? value_t'(0) : tail_upper;
    right     = last_in_row ? value_t'(0) : second_middle;
    wrap_in   = head;
    if (push) begin
      wrap_in.upper  = head.middle;
      wrap_in.middle = below;
    end
    line_ctrl.clear = frame_clear;
    line_ctrl.shift = push || (!aligned && (state != ST_DONE));
    eval_ctrl.clear = frame_clear;
    eval_ctrl.push  = push;
    eval_ctrl.check = (eff_row != '0);
  end

  glmf_line u_line (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (line_ctrl),
    .wrap_in       (wrap_in),
    .head          (head),
    .second_middle (second_middle),
    .tail_upper    (tail_upper)
  );

  glmf_eval u_eval (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (eval_ctrl),
    .centre     (head.middle),
    .up         (head.upper),
    .below      (below),
    .left       (left),
    .right      (right),
    .row        (eff_row),
    .col        (col_after),
    .count      (count),
    .any_found  (any_found),
    .best_value (best_value),
    .best_row   (best_row),
    .best_col   (best_col)
  );

  // Grid position, ring position and drain length.
  always_ff @(posedge clk) begin
    if (rst || frame_clear) begin
      col_pos    <= '0;
      row_pos    <= '0;
      ring_pos   <= '0;
      drain_left <= '0;
    end else begin
      if (line_ctrl.shift) begin
        ring_pos <= ring_pos + RING_BITS'(1);
      end
      if (push) begin
        col_pos <= last_in_row ? '0 : col_after;
        row_pos <= last_in_row ? row_inc(eff_row) : eff_row;
      end
      if (run_push && s_tlast) begin
        drain_left <= (last_in_row ? '0 : DRAIN_BITS'(ncols - col_after)) +
                      DRAIN_BITS'(ncols);
      end else if (drain_push) begin
        drain_left <= drain_left - DRAIN_BITS'(1);
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (frame_clear) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_clear) begin
      m_tuser <= any_found;
      m_tdata <= {1'b0,
                  any_found ? best_col : COL_BITS'(0),
                  any_found ? best_row : ROW_BITS'(0),
                  any_found ? best_value : value_t'(0),
                  count};
    end
  end

endmodule

`default_nettype wire

// ===== src/glmf_cell.sv =====
`default_nettype none

module glmf_cell
  import glmf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  line_ctrl_t ctrl,
  input  column_t    d,
  output column_t    q
);

  column_t data;

  // One column of both line buffers; zero is the padding row.
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      data <= '0;
    end else if (ctrl.shift) begin
      data <= d;
    end
  end

  assign q = data;

endmodule

`default_nettype wire

// ===== src/glmf_line.sv =====
`default_nettype none

module glmf_line
  import glmf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  line_ctrl_t ctrl,
  input  column_t    wrap_in,
  output column_t    head,
  output value_t     second_middle,
  output value_t     tail_upper
);

  column_t q [MAX_COLS];

  // A ring of cells: each shift moves every column one cell toward the head,
  // and the column leaving the head re-enters at the tail, updated or not.
  for (genvar i = 0; i < MAX_COLS; i++) begin : g_cell
    column_t d;
    if (i == MAX_COLS - 1) begin : g_tail
      assign d = wrap_in;
    end else begin : g_link
      assign d = q[i+1];
    end
    glmf_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .ctrl (ctrl),
      .d    (d),
      .q    (q[i])
    );
  end

  // The head holds the current column, its neighbors sit on either side.
  assign head          = q[0];
  assign second_middle = q[1].middle;
  assign tail_upper    = q[MAX_COLS-1].upper;

endmodule

`default_nettype wire

// ===== src/glmf_eval.sv =====
`default_nettype none

module glmf_eval
  import glmf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  eval_ctrl_t            ctrl,
  input  value_t                centre,
  input  value_t                up,
  input  value_t                below,
  input  value_t                left,
  input  value_t                right,
  input  logic [ROW_BITS-1:0]   row,
  input  logic [COL_BITS-1:0]   col,
  output logic [COUNT_BITS-1:0] count,
  output logic                  any_found,
  output value_t                best_value,
  output logic [ROW_BITS-1:0]   best_row,
  output logic [COL_BITS-1:0]   best_col
);

  logic is_min;

  // Strictly below all four neighbors, and only once a row lies above.
  assign is_min = ctrl.check && (centre < up) && (centre < below) &&
                  (centre < left) && (centre < right);

  // Count saturates; the first occurrence of the smallest value is kept.
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      count      <= '0;
      any_found  <= 1'b0;
      best_value <= '0;
      best_row   <= '0;
      best_col   <= '0;
    end else if (ctrl.push && is_min) begin
      if (count != '1) begin
        count <= count + COUNT_BITS'(1);
      end
      if (!any_found || (centre < best_value)) begin
        any_found  <= 1'b1;
        best_value <= centre;
        best_row   <= row;
        best_col   <= col;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/glmf_checker.sv =====
`default_nettype none

module glmf_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_tvalid,
  input wire        s_tready,
  input wire        s_tlast,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [47:0] m_tdata,
  input wire        m_tuser
);

  // A stalled result holds still.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // Without a minimum, value, row and column are all zero.
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[46:15] == 32'd0)
    else $error("nonzero position with no minimum");

  // With a minimum, count, row and column are all nonzero.
  a_found_set: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |->
      m_tdata[14:0] != 15'd0 && m_tdata[38:31] != 8'd0 && m_tdata[46:39] != 8'd0)
    else $error("found result with empty count or position");

  // The last cell of a grid starts the drain, which takes no input.
  a_drain_stall: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input taken right after the last cell");

endmodule

bind grid_local_minimum_finder glmf_checker u_glmf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
